// ===== hw/rtl/bbp_pkg.sv =====
// Shared types, constants and helpers for the biquadratic Bezier patch evaluator.
// Has no dependencies; every other file in hw/rtl imports it.
package bbp_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned WBITS      = FRAC_BITS + 1;
  localparam int unsigned NUM_GROUPS = 5;
  localparam int unsigned NUM_POINTS = 9;
  localparam int unsigned NUM_COMPS  = 4;
  localparam int unsigned MEM_DEPTH  = NUM_GROUPS * NUM_POINTS;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);
  localparam int unsigned DIV_STEPS  = 4;

  localparam logic [4:0] MAX_LEVEL = 5'd16;
  localparam logic [WBITS-1:0] ONE_W = WBITS'(1) << FRAC_BITS;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [2:0] GRP_POS    = 3'd0;
  localparam logic [2:0] GRP_NORMAL = 3'd1;
  localparam logic [2:0] GRP_TEX    = 3'd2;
  localparam logic [2:0] GRP_LMAP   = 3'd3;
  localparam logic [2:0] GRP_COLOR  = 3'd4;

  // Phases of the weight generator.
  localparam logic [2:0] PH_DIV_LAST = 3'd3;
  localparam logic [2:0] PH_W0       = 3'd4;
  localparam logic [2:0] PH_W1       = 3'd5;
  localparam logic [2:0] PH_W2       = 3'd6;

  // Blend sequencing: twelve multiply issues, then two pipeline stages.
  localparam logic [3:0] STEP_ISSUE_END = 4'd12;
  localparam logic [3:0] STEP_LAST      = 4'd13;
  localparam logic [1:0] K_LAST         = 2'd2;
  localparam logic [1:0] SLOT_FINAL     = 2'd3;

  typedef logic [WBITS-1:0] weight_t;
  typedef weight_t [2:0] wset_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        attr_group;
    logic [3:0]        point_index;
    logic [4:0]        grid_row;
    logic [4:0]        grid_col;
    logic signed [31:0] comp0;
    logic signed [31:0] comp1;
    logic signed [31:0] comp2;
    logic signed [31:0] comp3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        out_group;
    logic [4:0]        out_row;
    logic [4:0]        out_col;
    logic signed [31:0] res0;
    logic signed [31:0] res1;
    logic signed [31:0] res2;
    logic signed [31:0] res3;
  } out_item_t;

  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic              use_rows;
    logic              color;
    logic [1:0]        k;
    logic [1:0]        slot;
    logic [ADDR_W-1:0] raddr;
    weight_t           w;
  } lane_ctl_t;

  typedef enum logic [1:0] {ST_IDLE, ST_WGT, ST_BLEND, ST_DONE} state_e;

  function automatic logic [2:0] comps_of(input logic [2:0] g);
    logic [2:0] n;
    case (g)
      GRP_POS, GRP_NORMAL: n = 3'd3;
      GRP_TEX, GRP_LMAP:   n = 3'd2;
      GRP_COLOR:           n = 3'd4;
      default:             n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/bbp_wgen.sv =====
// Bernstein weight generator: divides row and column by the level, then forms b*b, 2ab, a*a.
// Depends on bbp_pkg.
module bbp_wgen import bbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0][4:0]  p_i,
  input  logic [4:0]       lvl_i,
  output logic             done_o,
  output wset_t [1:0]      w_o
);

  logic                    busy_q;
  logic [2:0]              cnt_q;
  logic [4:0]              lvl_q;
  logic [1:0]              full_q;
  logic [1:0][4:0]         rem_q, rem_d;
  logic [1:0][FRAC_BITS-1:0] quo_q, quo_d;
  wset_t [1:0]             w_q;
  weight_t [1:0]           wnew;

  // Four restoring-division steps per cycle for each of row and column.
  always_comb begin
    logic [4:0]           r;
    logic [5:0]           r2;
    logic [FRAC_BITS-1:0] q;
    weight_t              a, b, x, y;
    logic [2*WBITS-1:0]   prod;
    for (int i = 0; i < 2; i++) begin
      r = rem_q[i];
      q = quo_q[i];
      for (int s = 0; s < DIV_STEPS; s++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, lvl_q}) begin
          r = 5'(r2 - {1'b0, lvl_q});
          q = {q[FRAC_BITS-2:0], 1'b1};
        end else begin
          r = r2[4:0];
          q = {q[FRAC_BITS-2:0], 1'b0};
        end
      end
      rem_d[i] = r;
      quo_d[i] = q;
      a = full_q[i] ? ONE_W : {1'b0, quo_q[i]};
      b = ONE_W - a;
      case (cnt_q)
        PH_W0: begin x = b; y = b; end
        PH_W1: begin x = a; y = b; end
        default: begin x = a; y = a; end
      endcase
      prod = {{WBITS{1'b0}}, x} * {{WBITS{1'b0}}, y};
      wnew[i] = (cnt_q == PH_W1) ? prod[FRAC_BITS-1 +: WBITS] : prod[FRAC_BITS +: WBITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == PH_W2) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lvl_q <= lvl_i;
      for (int i = 0; i < 2; i++) begin
        rem_q[i]  <= p_i[i];
        quo_q[i]  <= '0;
        full_q[i] <= (p_i[i] == lvl_i);
      end
    end else if (busy_q) begin
      if (cnt_q <= PH_DIV_LAST) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      for (int i = 0; i < 2; i++) begin
        if (cnt_q == PH_W0) w_q[i][0] <= wnew[i];
        if (cnt_q == PH_W1) w_q[i][1] <= wnew[i];
        if (cnt_q == PH_W2) w_q[i][2] <= wnew[i];
      end
    end
  end

  assign done_o = busy_q && (cnt_q == PH_W2);
  assign w_o    = w_q;

endmodule

// ===== hw/rtl/bbp_lane.sv =====
// One component lane: its slice of the control store, a weighted-term multiplier and accumulator.
// Depends on bbp_pkg.
module bbp_lane import bbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  lane_ctl_t         ctl_i,
  output logic [31:0]       res_o
);

  logic [31:0]        mem_q [MEM_DEPTH];
  logic [31:0]        rd_q;
  lane_ctl_t          s1_q, s2_q;
  logic signed [49:0] prod_q, prod_d;
  logic signed [35:0] acc_q, sum_d;
  logic [31:0]        row_res_q [3];
  logic [31:0]        fin_q;
  logic [31:0]        op;
  logic [31:0]        res_d;
  logic signed [33:0] term;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (ctl_i.vld) rd_q <= mem_q[ctl_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= ctl_i;
      s2_q <= s1_q;
    end
  end

  // Color terms use only the low byte of their operand.
  always_comb begin
    op = s1_q.use_rows ? row_res_q[s1_q.k] : rd_q;
    if (s1_q.color) op = {24'd0, op[7:0]};
    prod_d = $signed(op) * $signed({1'b0, s1_q.w});
  end

  always_comb begin
    term  = prod_q[49:FRAC_BITS];
    sum_d = (s2_q.first ? 36'sd0 : acc_q) + {{2{term[33]}}, term};
    if (s2_q.color) begin
      res_d = {24'd0, sum_d[7:0]};
    end else if (sum_d[35:31] != {5{sum_d[35]}}) begin
      res_d = sum_d[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_d = sum_d[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.vld) prod_q <= prod_d;
    if (s2_q.vld) begin
      acc_q <= sum_d;
      if (s2_q.last) begin
        if (s2_q.slot == SLOT_FINAL) fin_q <= res_d;
        else row_res_q[s2_q.slot] <= res_d;
      end
    end
  end

  assign res_o = fin_q;

endmodule

// ===== hw/rtl/bbp_merge.sv =====
// Result stage: gathers the lane results into one beat and holds it until taken.
// Depends on bbp_pkg.
module bbp_merge import bbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [3:0][31:0] lanes_i,
  input  logic [2:0]       group_i,
  input  logic [4:0]       row_i,
  input  logic [4:0]       col_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_item_t        out_data_o,
  output logic             free_o
);

  logic       valid_q;
  out_item_t  data_q;
  logic [2:0] n;
  logic [3:0][31:0] masked;

  // Components past the group's count read as zero.
  always_comb begin
    n = comps_of(group_i);
    for (int c = 0; c < NUM_COMPS; c++) begin
      masked[c] = (3'(c) < n) ? lanes_i[c] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (load_i) valid_q <= 1'b1;
    else if (out_ready_i) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q.out_group <= group_i;
      data_q.out_row   <= row_i;
      data_q.out_col   <= col_i;
      data_q.res0      <= masked[0];
      data_q.res1      <= masked[1];
      data_q.res2      <= masked[2];
      data_q.res3      <= masked[3];
    end
  end

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/biquadratic_bezier_patch_eval_unit.sv =====
// Biquadratic Bezier patch evaluator. A load beat writes one control point of one
// attribute group and leaves the unit idle, ready for the next beat. An evaluate
// beat goes through the weight generator (division by the level, four quotient bits
// at a time, then three weight multiplies) and the four component lanes, whose single
// multiplier each runs nine row terms and three column terms through a two-stage
// pipeline; no beat is taken until its result is merged into the free output register.
// The finished result waits in that register while the next beat is accepted.
// Depends on bbp_pkg, bbp_wgen, bbp_lane and bbp_merge.
module biquadratic_bezier_patch_eval_unit import bbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  state_e             state_q, state_d;
  logic [4:0]         level_q, lvl_eff, row_c, col_c;
  logic [3:0]         step_q;
  logic [1:0]         k_q, j_q;
  logic [3:0]         pt_q;
  logic [2:0]         grp_q;
  logic [4:0]         row_q, col_q;
  logic               color_q;
  logic [ADDR_W-1:0]  base_q, base_in, waddr;
  logic               in_fire, we, eval_go, wgen_done, merge_load, merge_free;
  wset_t [1:0]        wts;
  lane_ctl_t          ctl;
  logic [3:0][31:0]   lane_res;
  logic [3:0][31:0]   wdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    if (level_q == 5'd0) lvl_eff = 5'd1;
    else if (level_q > MAX_LEVEL) lvl_eff = MAX_LEVEL;
    else lvl_eff = level_q;
    row_c = (in_data_i.grid_row > lvl_eff) ? lvl_eff : in_data_i.grid_row;
    col_c = (in_data_i.grid_col > lvl_eff) ? lvl_eff : in_data_i.grid_col;
    base_in = ADDR_W'({in_data_i.attr_group, 3'b000}) + ADDR_W'(in_data_i.attr_group);
    waddr   = base_in + ADDR_W'(in_data_i.point_index);
  end

  assign we = in_fire && (in_data_i.mode == MODE_LOAD) &&
              (in_data_i.attr_group < NUM_GROUPS) && (in_data_i.point_index < NUM_POINTS);
  assign eval_go = in_fire && (in_data_i.mode == MODE_EVAL) &&
                   (in_data_i.attr_group < NUM_GROUPS);

  assign wdata = {in_data_i.comp3, in_data_i.comp2, in_data_i.comp1, in_data_i.comp0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 5'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      level_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      k_q     <= '0;
      j_q     <= '0;
      pt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_BLEND) begin
        step_q <= '0;
        k_q    <= '0;
        j_q    <= '0;
        pt_q   <= '0;
      end else begin
        step_q <= step_q + 4'd1;
        if (step_q < STEP_ISSUE_END) begin
          pt_q <= pt_q + 4'd1;
          if (k_q == K_LAST) begin
            k_q <= '0;
            j_q <= j_q + 2'd1;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      grp_q   <= in_data_i.attr_group;
      row_q   <= row_c;
      col_q   <= col_c;
      color_q <= (in_data_i.attr_group == GRP_COLOR);
      base_q  <= base_in;
    end
  end

  always_comb begin
    state_d    = state_q;
    merge_load = 1'b0;
    ctl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (eval_go) state_d = ST_WGT;
      end
      ST_WGT: begin
        if (wgen_done) state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (step_q < STEP_ISSUE_END) begin
          ctl.vld      = 1'b1;
          ctl.first    = (k_q == 2'd0);
          ctl.last     = (k_q == K_LAST);
          ctl.use_rows = (j_q == SLOT_FINAL);
          ctl.color    = color_q;
          ctl.k        = k_q;
          ctl.slot     = j_q;
          ctl.raddr    = base_q + ADDR_W'(pt_q);
          ctl.w        = (j_q == SLOT_FINAL) ? wts[1][k_q] : wts[0][k_q];
        end
        if (step_q == STEP_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  bbp_wgen u_wgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eval_go),
    .p_i     ({col_c, row_c}),
    .lvl_i   (lvl_eff),
    .done_o  (wgen_done),
    .w_o     (wts)
  );

  for (genvar c = 0; c < NUM_COMPS; c++) begin : g_lane
    bbp_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata[c]),
      .ctl_i   (ctl),
      .res_o   (lane_res[c])
    );
  end

  bbp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .lanes_i     (lane_res),
    .group_i     (grp_q),
    .row_i       (row_q),
    .col_i       (col_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (merge_free)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the biquadratic Bezier patch evaluator.
// Drives load and evaluate beats, predicts each evaluated vertex, and compares it.
// Depends on bbp_pkg and biquadratic_bezier_patch_eval_unit.
`timescale 1ns / 1ps
module testbench;
  import bbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t item;
    logic     has_want;
    out_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_data_i = 5'd1;

  logic [31:0] patch_mem [NUM_GROUPS][NUM_POINTS][NUM_COMPS];
  logic [4:0] level_reg;
  out_item_t vertex_q [$];
  int mismatches = 0;
  int cycles = 0;
  stim_row_t rows [$];

  biquadratic_bezier_patch_eval_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint floor_q(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic void weights_at(int p, int lvl, output longint w[3]);
    longint a, b;
    a = (longint'(p) << FRAC_BITS) / lvl;
    b = (longint'(1) << FRAC_BITS) - a;
    w[0] = (b * b) >> FRAC_BITS;
    w[1] = (2 * a * b) >> FRAC_BITS;
    w[2] = (a * a) >> FRAC_BITS;
  endfunction

  function automatic longint mix3(longint c[3], longint w[3], bit is_color);
    longint s;
    s = 0;
    for (int k = 0; k < 3; k++)
      s += floor_q((is_color ? (c[k] & 255) : c[k]) * w[k]);
    if (is_color) return s & 255;
    if (s > 64'sd2147483647) return 64'sd2147483647;
    if (s < -64'sd2147483648) return -64'sd2147483648;
    return s;
  endfunction

  // Applies one beat to the model store; returns 1 with the vertex when one is due.
  function automatic bit eval_vertex(in_item_t it, output out_item_t v);
    int lvl, r, c, n;
    longint wr[3], wc[3], pts[3], rr[3], res[4];
    v = '0;
    if (it.attr_group >= NUM_GROUPS) return 0;
    if (it.mode == MODE_LOAD) begin
      if (it.point_index < NUM_POINTS) begin
        patch_mem[it.attr_group][it.point_index] =
          '{it.comp0, it.comp1, it.comp2, it.comp3};
      end
      return 0;
    end
    lvl = (level_reg == 0) ? 1 : (level_reg > MAX_LEVEL ? MAX_LEVEL : level_reg);
    r = (it.grid_row > lvl) ? lvl : it.grid_row;
    c = (it.grid_col > lvl) ? lvl : it.grid_col;
    weights_at(r, lvl, wr);
    weights_at(c, lvl, wc);
    n = comps_of(it.attr_group);
    for (int q = 0; q < 4; q++) begin
      res[q] = 0;
      if (q < n) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++)
            pts[k] = longint'($signed(patch_mem[it.attr_group][3*j+k][q]));
          rr[j] = mix3(pts, wr, it.attr_group == GRP_COLOR);
        end
        res[q] = mix3(rr, wc, it.attr_group == GRP_COLOR);
      end
    end
    v.out_group = it.attr_group;
    v.out_row = r[4:0];
    v.out_col = c[4:0];
    v.res0 = res[0][31:0];
    v.res1 = res[1][31:0];
    v.res2 = res[2][31:0];
    v.res3 = res[3][31:0];
    return 1;
  endfunction

  // Valid stays high between beats with no gap; it drops only where a gap follows.
  task automatic send_beat(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_beat(in_item_t it);
    out_item_t v;
    if (eval_vertex(it, v)) vertex_q.push_back(v);
    send_beat(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic set_level(logic [4:0] lvl);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lvl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    level_reg = lvl;
  endtask

  function automatic in_item_t load_item(int g, int p, logic [31:0] c0, logic [31:0] c1,
                                         logic [31:0] c2, logic [31:0] c3);
    in_item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.attr_group = 3'(g);
    it.point_index = 4'(p);
    it.grid_row = 5'($urandom);
    it.grid_col = 5'($urandom);
    it.comp0 = c0;
    it.comp1 = c1;
    it.comp2 = c2;
    it.comp3 = c3;
    return it;
  endfunction

  function automatic in_item_t eval_item(int g, int r, int c);
    in_item_t it;
    it = '0;
    it.mode = MODE_EVAL;
    it.attr_group = 3'(g);
    it.point_index = 4'($urandom);
    it.grid_row = 5'(r);
    it.grid_col = 5'(c);
    it.comp0 = $urandom;
    it.comp1 = $urandom;
    it.comp2 = $urandom;
    it.comp3 = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_comp(int g);
    int s;
    if (g == GRP_COLOR) return $urandom;
    s = $urandom_range(0, 9);
    if (s == 0) return 32'h7fffffff;
    if (s == 1) return 32'h80000000;
    if (s < 5) return $urandom;
    return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
  endfunction

  task automatic load_group(int g);
    for (int p = 0; p < NUM_POINTS; p++)
      apply_beat(load_item(g, p, rand_comp(g), rand_comp(g), rand_comp(g), rand_comp(g)));
  endtask

  // Receiver: random stalls, compare each vertex with the oldest prediction.
  initial begin
    out_item_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 3) != 0) || (gap_len() == 0);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected vertex %p", out_data_o);
        end else begin
          want = vertex_q.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Vertex mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t v;
    int g;
    level_reg = 5'd1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: extremes at level 1, where the corners are the control points.
    for (int p = 0; p < NUM_POINTS; p++)
      rows.push_back('{load_item(GRP_POS, p, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                 32'h12345678), 1'b0, '0});
    rows.push_back('{eval_item(GRP_POS, 0, 0), 1'b1,
                     '{GRP_POS, 5'd0, 5'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0}});
    // Row and column beyond the level are clamped.
    rows.push_back('{eval_item(GRP_POS, 31, 31), 1'b1,
                     '{GRP_POS, 5'd1, 5'd1, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0}});
    // A bad group or point index is ignored.
    rows.push_back('{load_item(7, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{load_item(GRP_POS, 15, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{eval_item(5, 0, 0), 1'b0, '0});
    for (int p = 0; p < NUM_POINTS; p++)
      rows.push_back('{load_item(GRP_COLOR, p, 32'h1ff, 32'hffffff80, 32'd0, 32'd255),
                       1'b0, '0});
    rows.push_back('{eval_item(GRP_COLOR, 1, 0), 1'b1,
                     '{GRP_COLOR, 5'd1, 5'd0, 32'd255, 32'd128, 32'd0, 32'd255}});
    foreach (rows[i]) begin
      if (rows[i].has_want) begin
        void'(eval_vertex(rows[i].item, v));
        vertex_q.push_back(rows[i].want);
        send_beat(rows[i].item);
      end else
        apply_beat(rows[i].item);
    end

    for (int gg = 0; gg < NUM_GROUPS; gg++) load_group(gg);

    // Random phases through several levels, zero and the top of the field among them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_level(5'd0);
        1: set_level(5'd16);
        2: set_level(5'd31);
        3: set_level(5'd1);
        default: set_level(5'($urandom_range(2, 15)));
      endcase
      for (int n = 0; n < 100; n++) begin
        g = $urandom_range(0, 9);
        if (g < 7) begin
          g = $urandom_range(0, 4);
          apply_beat(eval_item(g, $urandom_range(0, 17), $urandom_range(0, 17)));
        end else if (g < 9) begin
          g = $urandom_range(0, 4);
          apply_beat(load_item(g, $urandom_range(0, 8), rand_comp(g), rand_comp(g),
                               rand_comp(g), rand_comp(g)));
        end else begin
          it = '0;
          it.mode = 1'($urandom);
          it.attr_group = 3'($urandom_range(5, 7));
          it.point_index = 4'($urandom);
          it.grid_row = 5'($urandom);
          it.grid_col = 5'($urandom);
          it.comp0 = $urandom;
          apply_beat(it);
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bbp_pkg.sv
hw/rtl/bbp_wgen.sv
hw/rtl/bbp_lane.sv
hw/rtl/bbp_merge.sv
hw/rtl/biquadratic_bezier_patch_eval_unit.sv
dv/testbench.sv
